/* hw/rtl/b64u_pkg.sv */
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, codes and the sextet-to-character mapping of the encoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

    // position of the next byte inside its three-byte group
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3d;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_output;
    } t_out_item;

    // characters one input byte gives, slot 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            mark_last;
    } t_job;

    // url-safe alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2d;
        end else begin
            c = 8'h5f;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/b64u_front.sv */
// ----------------------------------------------------------------------------
// b64u_front
// Tracks group phase and leftover bits, turns each byte into a character job.
// ----------------------------------------------------------------------------
module b64u_front import b64u_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_job     o_job
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left,  n_left;

    always_comb begin
        logic [7:0] b;
        b       = i_item.data_byte;
        o_job   = '0;
        n_phase = PHASE_0;
        n_left  = '0;
        unique case (r_phase)
            PHASE_1: begin
                o_job.chars[0] = sextet_char({r_left[1:0], b[7:4]});
                if (i_item.final_byte) begin
                    o_job.chars[1]  = sextet_char({b[3:0], 2'b00});
                    o_job.chars[2]  = PAD_CHAR;
                    o_job.last_idx  = 2'd2;
                    o_job.mark_last = 1'b1;
                end else begin
                    n_phase = PHASE_2;
                    n_left  = b[3:0];
                end
            end
            PHASE_2: begin
                o_job.chars[0]  = sextet_char({r_left, b[7:6]});
                o_job.chars[1]  = sextet_char(b[5:0]);
                o_job.last_idx  = 2'd1;
                o_job.mark_last = i_item.final_byte;
            end
            default: begin
                o_job.chars[0] = sextet_char(b[7:2]);
                if (i_item.final_byte) begin
                    o_job.chars[1]  = sextet_char({b[1:0], 4'b0000});
                    o_job.chars[2]  = PAD_CHAR;
                    o_job.chars[3]  = PAD_CHAR;
                    o_job.last_idx  = 2'd3;
                    o_job.mark_last = 1'b1;
                end else begin
                    n_phase = PHASE_1;
                    n_left  = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_0;
            r_left  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

/* hw/rtl/b64u_queue.sv */
// ----------------------------------------------------------------------------
// b64u_queue
// Small register queue of character jobs between front and back.
// ----------------------------------------------------------------------------
module b64u_queue import b64u_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr, rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/b64u_back.sv */
// ----------------------------------------------------------------------------
// b64u_back
// Serializes jobs into an output register, one char per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64u_back import b64u_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_valid,
    output logic      o_job_pop,
    output t_out_item o_item,
    output logic      o_empty,
    input  logic      i_pop
);

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    t_out_item  r_out;
    logic       r_out_valid;
    logic       adv, job_done;

    // output slot free or being taken this cycle
    assign adv      = !r_out_valid || i_pop;
    assign job_done = r_busy && adv && (r_idx == r_job.last_idx);
    assign o_job_pop = i_job_valid && (!r_busy || job_done);

    assign o_item  = r_out;
    assign o_empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (adv && r_busy) begin
            r_out.out_char      <= r_job.chars[r_idx];
            r_out.end_of_output <= r_job.mark_last && (r_idx == r_job.last_idx);
        end
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_busy;
            end
            if (o_job_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (job_done) begin
                r_busy <= 1'b0;
            end else if (adv && r_busy) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/base64url_encoder_top.sv */
// ----------------------------------------------------------------------------
// base64url_encoder_top
// URL-safe base64 encoder with '=' padding, one byte in, characters out.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  input     push / full       i_in_item  (data_byte, final_byte)
//  result    empty / pop       o_out_item (out_char, end_of_output)
//
//  a byte is taken in the cycle it arrives whenever the job queue has room
//  the back end sends one character per cycle while the output is free or
//  being popped and a job is queued, 1 to 4 characters per byte
//  synchronous active-low reset clears phase, queue and output valid flag
//  a stalled result side fills the queue, then full holds off the input
// ----------------------------------------------------------------------------
module base64url_encoder_top import b64u_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    t_job front_job;
    t_job queue_job;
    logic queue_valid;
    logic queue_pop;
    logic in_accept;

    // input transfer
    assign in_accept = push && !full;

    // front: phase tracking and character generation for each byte
    b64u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_job    (front_job)
    );

    // decoupling queue, one job per accepted byte
    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_job   (queue_job),
        .o_valid (queue_valid)
    );

    // back: one character per cycle into the output register unless stalled by pop
    b64u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_job_valid (queue_valid),
        .o_job_pop   (queue_pop),
        .o_item      (o_out_item),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

/* tb/tb_base64url_encoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64url_encoder_top
// Self-checking bench for the url-safe base64 encoder. A short table of
// hand-picked bytes (with hand-typed characters where they are obvious) is
// followed by random messages of random length; every character transfer is
// compared field by field against the typed characters or an in-bench encoder
// model, while both sides idle and stall at random in most phases.
// ----------------------------------------------------------------------------
module tb_base64url_encoder_top import b64u_pkg::*; ();

    // alphabet as one packed constant, first character in the top byte
    localparam logic [8*64-1:0] URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    localparam int ITEMS_PER_PHASE = 31;
    localparam int TAIL_CYCLES     = 16;

    // one row of stimulus; pin_count > 0 means the characters are typed in
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        final_byte;
        logic [2:0]  pin_count;
        logic [31:0] pin_text;
    } t_vector;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_out_item;

    // typed-in characters travel with the byte they belong to
    logic        pin_active;
    logic [2:0]  pin_count;
    logic [31:0] pin_text;

    // encoder model state
    logic [1:0]  enc_phase = PHASE_0;
    logic [3:0]  enc_left  = 4'd0;
    t_out_item   burst[$];

    // characters still owed by the block, oldest first
    t_out_item   pending_chars[$];
    t_vector     directed_vectors[$];

    int          tx_idle_pct;
    int          rx_idle_pct;
    int          mismatch_count = 0;

    base64url_encoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // encoder model
    // ------------------------------------------------------------------------
    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] sextet);
        return URL_ALPHABET[8*(63 - int'(sextet)) +: 8];
    endfunction

    function void add_char(input logic [7:0] ch, input logic last);
        t_out_item c;
        c.out_char      = ch;
        c.end_of_output = last;
        burst.push_back(c);
    endfunction

    // one byte in, 1 to 4 characters into burst
    function void encode_byte(input t_in_item it);
        logic [7:0] b;
        b = it.data_byte;
        case (enc_phase)
            PHASE_1: begin
                // two leftover bits join the high nibble
                add_char(sextet_to_ascii({enc_left[1:0], b[7:4]}), 1'b0);
                if (it.final_byte) begin
                    add_char(sextet_to_ascii({b[3:0], 2'b00}), 1'b0);
                    add_char(PAD_CHAR, 1'b1);
                    enc_phase = PHASE_0;
                    enc_left  = 4'd0;
                end else begin
                    enc_left  = b[3:0];
                    enc_phase = PHASE_2;
                end
            end
            PHASE_2: begin
                // group complete, two characters whether final or not
                add_char(sextet_to_ascii({enc_left, b[7:6]}), 1'b0);
                add_char(sextet_to_ascii(b[5:0]), it.final_byte);
                enc_phase = PHASE_0;
                enc_left  = 4'd0;
            end
            default: begin
                // start of a group, an out-of-range phase lands here too
                add_char(sextet_to_ascii(b[7:2]), 1'b0);
                if (it.final_byte) begin
                    add_char(sextet_to_ascii({b[1:0], 4'b0000}), 1'b0);
                    add_char(PAD_CHAR, 1'b0);
                    add_char(PAD_CHAR, 1'b1);
                    enc_phase = PHASE_0;
                    enc_left  = 4'd0;
                end else begin
                    enc_left  = {2'b00, b[1:0]};
                    enc_phase = PHASE_1;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // input side: every accepted byte queues its characters
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item c;
        if (!i_rst_n) begin
            enc_phase = PHASE_0;
            enc_left  = 4'd0;
        end else if (push && !full) begin
            burst.delete();
            encode_byte(i_in_item);
            if (pin_active) begin
                // typed characters replace the model's, model state still moves
                for (int k = 0; k < pin_count; k++) begin
                    c.out_char      = pin_text[8*(pin_count - 1 - k) +: 8];
                    c.end_of_output = i_in_item.final_byte && (k == pin_count - 1);
                    pending_chars.push_back(c);
                end
            end else begin
                foreach (burst[k]) pending_chars.push_back(burst[k]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: random pop, check each character transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected transfer: out_char %h end_of_output %b",
                           o_out_item.out_char, o_out_item.end_of_output);
                    mismatch_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_out_item.out_char !== want.out_char) begin
                        $error("out_char: expected %h, got %h",
                               want.out_char, o_out_item.out_char);
                        mismatch_count++;
                    end
                    if (o_out_item.end_of_output !== want.end_of_output) begin
                        $error("end_of_output: expected %b, got %b",
                               want.end_of_output, o_out_item.end_of_output);
                        mismatch_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // random idle cycles, then hold push until the transfer happens
    task automatic send_item(input t_vector v);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push                 <= 1'b1;
        i_in_item.data_byte  <= v.data_byte;
        i_in_item.final_byte <= v.final_byte;
        pin_active           <= (v.pin_count != 3'd0);
        pin_count            <= v.pin_count;
        pin_text             <= v.pin_text;
        do @(posedge i_clk); while (full);
    endtask

    // stop sending until every owed character has come out
    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // mostly short messages, a few long ones, extremes now and then
    task automatic send_random_messages(input int item_goal);
        int      sent;
        int      len;
        t_vector v;
        sent = 0;
        while (sent < item_goal) begin
            len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
            for (int i = 0; i < len; i++) begin
                v = '0;
                case ($urandom_range(9))
                    0:       v.data_byte = 8'h00;
                    1:       v.data_byte = 8'hff;
                    default: v.data_byte = 8'($urandom_range(255));
                endcase
                v.final_byte = (i == len - 1);
                send_item(v);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_in_item   = '0;
        pin_active  = 1'b0;
        pin_count   = 3'd0;
        pin_text    = 32'd0;
        tx_idle_pct = 25;
        rx_idle_pct = 88;

        // single-byte messages at both extremes, double pad
        directed_vectors.push_back('{8'h00, 1'b1, 3'd4, "AA=="});
        directed_vectors.push_back('{8'hff, 1'b1, 3'd4, "_w=="});
        // full group of ones, end mark on the second char of phase 2
        directed_vectors.push_back('{8'hff, 1'b0, 3'd1, "_"});
        directed_vectors.push_back('{8'hff, 1'b0, 3'd1, "_"});
        directed_vectors.push_back('{8'hff, 1'b1, 3'd2, "__"});
        // two-byte message, single pad
        directed_vectors.push_back('{8'h00, 1'b0, 3'd1, "A"});
        directed_vectors.push_back('{8'h00, 1'b1, 3'd3, "AA="});
        // three zero bytes, no pad
        directed_vectors.push_back('{8'h00, 1'b0, 3'd1, "A"});
        directed_vectors.push_back('{8'h00, 1'b0, 3'd1, "A"});
        directed_vectors.push_back('{8'h00, 1'b1, 3'd2, "AA"});
        // phase 2 without final, then a group closed in phase 1
        directed_vectors.push_back('{8'h4d, 1'b0, 3'd0, 32'd0});
        directed_vectors.push_back('{8'h61, 1'b0, 3'd0, 32'd0});
        directed_vectors.push_back('{8'h6e, 1'b0, 3'd0, 32'd0});
        directed_vectors.push_back('{8'h4d, 1'b0, 3'd0, 32'd0});
        directed_vectors.push_back('{8'h61, 1'b1, 3'd0, 32'd0});
        // dash characters
        directed_vectors.push_back('{8'hfb, 1'b0, 3'd0, 32'd0});
        directed_vectors.push_back('{8'hef, 1'b0, 3'd0, 32'd0});
        directed_vectors.push_back('{8'hbe, 1'b1, 3'd0, 32'd0});
        // single bits at top and bottom
        directed_vectors.push_back('{8'h80, 1'b1, 3'd0, 32'd0});
        directed_vectors.push_back('{8'h01, 1'b1, 3'd0, 32'd0});
        // a group through every phase, top sextet in phase 2, then one lone byte
        directed_vectors.push_back('{8'h3e, 1'b0, 3'd0, 32'd0});
        directed_vectors.push_back('{8'h3f, 1'b0, 3'd0, 32'd0});
        directed_vectors.push_back('{8'hfc, 1'b1, 3'd0, 32'd0});
        directed_vectors.push_back('{8'h7f, 1'b1, 3'd0, 32'd0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_vectors[i]) send_item(directed_vectors[i]);
        // hold off input until the block is empty
        wait_for_drain();

        // slow receiver
        send_random_messages(ITEMS_PER_PHASE);
        wait_for_drain();

        // slow sender
        tx_idle_pct = 88;
        rx_idle_pct = 25;
        send_random_messages(ITEMS_PER_PHASE);
        wait_for_drain();

        // back to back on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_messages(ITEMS_PER_PHASE);
        wait_for_drain();

        // catch any stray character after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
